@@ rtl/aes_pkg.sv @@
// aes-128 package: s-box tables, gf(2^8) helpers and round functions
// used by the cipher pipeline; no dependencies
package aes_pkg;

  localparam int unsigned Rounds = 10;

  typedef logic [127:0] blk_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

  // byte n of the block lives at bits [127-8n -: 8]
  function automatic logic [7:0] byt(input blk_t s, input int n);
    byt = s[127-8*n -: 8];
  endfunction

  function automatic blk_t fwd_round(input blk_t s, input blk_t k, input logic last);
    blk_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = sbox(byt(s, r + 4*((c+r) & 3)));
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = byt(t, 4*c); a1 = byt(t, 4*c+1); a2 = byt(t, 4*c+2); a3 = byt(t, 4*c+3);
        t[127-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    fwd_round = t ^ k;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p, x;
    p = '0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gm = p;
  endfunction

  // inverse round: inv shift rows, inv sub bytes, add key, inv mix columns (skipped when last)
  function automatic blk_t inv_round(input blk_t s, input blk_t k, input logic last);
    blk_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r + 4*((c+r) & 3)) -: 8] = inv_sbox(byt(s, r+4*c));
      end
    end
    t = t ^ k;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = byt(t, 4*c); a1 = byt(t, 4*c+1); a2 = byt(t, 4*c+2); a3 = byt(t, 4*c+3);
        t[127-8*(4*c)   -: 8] = gm(a0,4'd14) ^ gm(a1,4'd11) ^ gm(a2,4'd13) ^ gm(a3,4'd9);
        t[127-8*(4*c+1) -: 8] = gm(a0,4'd9) ^ gm(a1,4'd14) ^ gm(a2,4'd11) ^ gm(a3,4'd13);
        t[127-8*(4*c+2) -: 8] = gm(a0,4'd13) ^ gm(a1,4'd9) ^ gm(a2,4'd14) ^ gm(a3,4'd11);
        t[127-8*(4*c+3) -: 8] = gm(a0,4'd11) ^ gm(a1,4'd13) ^ gm(a2,4'd9) ^ gm(a3,4'd14);
      end
    end
    inv_round = t;
  endfunction

  function automatic blk_t next_key(input blk_t p, input logic [7:0] rc);
    blk_t n;
    n[127 -: 32] = p[127 -: 32] ^ {sbox(byt(p,13)) ^ rc, sbox(byt(p,14)),
                                   sbox(byt(p,15)), sbox(byt(p,12))};
    n[95 -: 32] = p[95 -: 32] ^ n[127 -: 32];
    n[63 -: 32] = p[63 -: 32] ^ n[95 -: 32];
    n[31 -: 32] = p[31 -: 32] ^ n[63 -: 32];
    next_key = n;
  endfunction

  function automatic logic [7:0] rcon(input int r);
    logic [7:0] x;
    x = 8'h01;
    for (int i = 1; i < 10; i++) begin
      if (i < r) x = xtime(x);
    end
    rcon = x;
  endfunction

endpackage

@@ rtl/aes_if.sv @@
// valid/ready stream channels for the cipher block
// depends on nothing
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, op, block_high, block_low, input ready);
  modport sink   (input valid, op, block_high, block_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

@@ rtl/aes128_block_cipher.sv @@
// aes-128 cipher: 11-stage pipeline, input stage then one round per stage, round keys precomputed
// depends on aes_pkg and the stream interfaces in aes_if.sv
//
// Accepts one block per cycle unless the output stalls or the key hold-off is
// on, and passes it through one stage for the input register and initial key
// add, then ten round stages, the last of which drives the outputs. The whole
// pipe advances when the last stage is empty or being taken. The eleven round
// keys are expanded from the key registers one round per cycle. After reset and
// after every key write the input is held off while that expansion settles.
// Keys must only be written while the pipe is empty; the block does not enforce it.
module aes128_block_cipher import aes_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [3:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic       pready,
  aes_in_if.sink     in_if,
  aes_out_if.source  out_if
);

  localparam int unsigned Stages = Rounds + 1;

  logic [63:0] key_hi_q, key_lo_q;
  blk_t        rk_q [Rounds+1];
  blk_t        st_q [Stages];
  logic        op_q [Stages];
  logic [Stages-1:0] vld_q;
  logic        adv;
  logic        key_wr;
  logic [3:0]  kwait_q, kwait_d;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? key_lo_q : key_hi_q;
  assign key_wr = psel && penable && pwrite && paddr[2:0] == 3'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (key_wr) begin
      if (paddr[3]) key_lo_q <= pwdata;
      else          key_hi_q <= pwdata;
    end
  end

  // key schedule chain, one register per round key, settles after a key write
  always_ff @(posedge clk_i) begin
    rk_q[0] <= {key_hi_q, key_lo_q};
    for (int r = 1; r <= Rounds; r++) begin
      rk_q[r] <= next_key(rk_q[r-1], rcon(r));
    end
  end

  // hold off input until the round keys match the key registers
  always_comb begin
    kwait_d = kwait_q;
    if (key_wr) begin
      kwait_d = 4'(Rounds + 1);
    end else if (kwait_q != '0) begin
      kwait_d = kwait_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kwait_q <= 4'(Rounds + 1);
    end else begin
      kwait_q <= kwait_d;
    end
  end

  assign adv = !vld_q[Stages-1] || out_if.ready;
  assign in_if.ready = adv && (kwait_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_if.valid && in_if.ready};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q[0] <= in_if.op;
      st_q[0] <= {in_if.block_high, in_if.block_low} ^
                 (in_if.op ? rk_q[Rounds] : rk_q[0]);
      for (int s = 1; s < Stages; s++) begin
        op_q[s] <= op_q[s-1];
        st_q[s] <= op_q[s-1] ? inv_round(st_q[s-1], rk_q[Rounds-s], s == Rounds)
                             : fwd_round(st_q[s-1], rk_q[s], s == Rounds);
      end
    end
  end

  assign out_if.valid       = vld_q[Stages-1];
  assign out_if.result_high = st_q[Stages-1][127:64];
  assign out_if.result_low  = st_q[Stages-1][63:0];

endmodule

@@ rtl/aes_checker.sv @@
// port-level checks for the cipher block, bound to the top level
// depends on the top level's port names
module aes_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [127:0] out_data
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output dropped");
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> (!out_valid || out_ready)) else $error("input ready wrong");
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
endmodule

bind aes128_block_cipher aes_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_data({out_if.result_high, out_if.result_low}));
